### rtl/sfd_pkg.sv
// Shared widths, types and register codes for the spring force block.
`timescale 1ns / 1ps

package sfd_pkg;

   // Axis count and field widths.
   localparam int NUM_AX  = 3;
   localparam int DW      = 32;
   localparam int DIFF_W  = DW + 1;                // separation per axis
   localparam int SQ_W    = 2 * DIFF_W;            // squared length
   localparam int ROOT_W  = DIFF_W;                // spring length
   localparam int PROD_W  = DIFF_W + DW;           // |d| * stiffness
   localparam int SMAG_W  = ROOT_W;                // |L - rest_length|
   localparam int SPLIT_W = DIFF_W;                // low part of the wide product
   localparam int FULL_W  = PROD_W + SMAG_W;       // full force numerator
   localparam int FRAC_W  = 16;
   localparam int NUM_W   = FULL_W - FRAC_W;       // numerator after the Q16 scale
   localparam int Q_W     = DW;                    // quotient bits before saturation
   localparam int AX_X    = 0;

   // Periodic wrap of the x separation: below -10.0, add 20.0.
   localparam logic signed [DIFF_W-1:0] WRAP_LIMIT = -33'sd655360;
   localparam logic signed [DIFF_W-1:0] WRAP_SHIFT = 33'sd1310720;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 8;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REST_LENGTH = 8'd0,
      CSR_STIFFNESS   = 8'd1
   } csr_idx_type;

   typedef logic [NUM_AX-1:0][DW-1:0]     pos_type;
   typedef logic [NUM_AX-1:0][DW-1:0]     frc_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic [SQ_W-1:0]               sq_type;
   typedef logic [NUM_AX-1:0][NUM_W-1:0]  numer_type;

   // Separation magnitudes and signs that travel beside the root.
   typedef struct packed {
      logic [NUM_AX-1:0]              sgn;
      logic [NUM_AX-1:0][DIFF_W-1:0]  mag;
   } sep_type;

   // Per-item control that travels beside the divider.
   typedef struct packed {
      logic [NUM_AX-1:0]  neg;
      logic               degen;
      logic [ROOT_W-1:0]  len;
   } div_side_type;

   // One result item.
   typedef struct packed {
      logic             degen;
      logic [DW-1:0]    span;
      frc_type          frc;
   } res_type;

endpackage

### rtl/sfd_front.sv
// Front stages: separation with x wrap, magnitudes, squares and their sum.
`timescale 1ns / 1ps

module sfd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  sfd_pkg::pos_type first_pos,
   input  sfd_pkg::pos_type second_pos,
   output logic             out_valid,
   output sfd_pkg::sq_type  sum_sq,
   output sfd_pkg::sep_type sep
);
   import sfd_pkg::*;

   logic [3:0]                     vld_ff;
   logic [NUM_AX-1:0][DIFF_W-1:0]  d_ff, d_in;
   sep_type                        sep2_ff, sep2_in;
   sep_type                        sep3_ff, sep4_ff;
   logic [NUM_AX-1:0][SQ_W-1:0]    sq_ff, sq_in;
   sq_type                         sum_ff, sum_in;

   // Stage 1: signed separation, x wrapped once when far negative.
   always_comb begin
      for (int i = 0; i < NUM_AX; i++) begin
         d_in[i] = $signed({first_pos[i][DW-1], first_pos[i]})
                 - $signed({second_pos[i][DW-1], second_pos[i]});
      end
      if ($signed(d_in[AX_X]) < WRAP_LIMIT) begin
         d_in[AX_X] = d_in[AX_X] + WRAP_SHIFT;
      end
   end

   // Stage 2: magnitude and sign per axis.
   always_comb begin
      for (int i = 0; i < NUM_AX; i++) begin
         sep2_in.sgn[i] = d_ff[i][DIFF_W-1];
         sep2_in.mag[i] = d_ff[i][DIFF_W-1] ? DIFF_W'(-d_ff[i]) : d_ff[i];
      end
   end

   // Stage 3: one square per axis.
   always_comb begin
      for (int i = 0; i < NUM_AX; i++) begin
         sq_in[i] = sep2_ff.mag[i] * sep2_ff.mag[i];
      end
   end

   // Stage 4: sum of squares.
   assign sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         sep2_ff <= sep2_in;
         sq_ff   <= sq_in;
         sep3_ff <= sep2_ff;
         sum_ff  <= sum_in;
         sep4_ff <= sep3_ff;
      end
   end

   assign out_valid = vld_ff[3];
   assign sum_sq    = sum_ff;
   assign sep       = sep4_ff;

endmodule

### rtl/sfd_sqrt.sv
// Integer square root, one root bit per pipeline stage.
`timescale 1ns / 1ps

module sfd_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  sfd_pkg::sq_type             radicand,
   input  sfd_pkg::sep_type            sep_in,
   output logic                        out_valid,
   output logic [sfd_pkg::ROOT_W-1:0]  root,
   output sfd_pkg::sep_type            sep_out
);
   import sfd_pkg::*;

   logic [SQ_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]  root_ff [ROOT_W];
   sep_type            sep_ff  [ROOT_W];
   logic [ROOT_W-1:0]  vld_ff;

   genvar k;
   for (k = 0; k < ROOT_W; k++) begin : g_step
      localparam int BIT = ROOT_W - 1 - k;
      logic [SQ_W-1:0]    rem_src;
      logic [ROOT_W-1:0]  root_src;
      sep_type            sep_src;
      logic               vld_src;
      logic [SQ_W+1:0]    trial;
      logic               fits;

      if (k == 0) begin : g_first
         assign rem_src  = radicand;
         assign root_src = '0;
         assign sep_src  = sep_in;
         assign vld_src  = in_valid;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign sep_src  = sep_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      // Try this bit: subtract (2*root + bit) * bit from the remainder.
      always_comb begin
         trial = ({(SQ_W+2-ROOT_W)'(0), root_src} << (BIT + 1))
               | ((SQ_W+2)'(1) << (2 * BIT));
         fits  = {2'b00, rem_src} >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= fits ? SQ_W'({2'b00, rem_src} - trial) : rem_src;
            root_ff[k] <= fits ? (root_src | (ROOT_W'(1) << BIT)) : root_src;
            sep_ff[k]  <= sep_src;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign sep_out   = sep_ff[ROOT_W-1];

endmodule

### rtl/sfd_scale.sv
// Stretch and wide products that form the force numerators.
`timescale 1ns / 1ps

module sfd_scale (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [sfd_pkg::ROOT_W-1:0]  len,
   input  sfd_pkg::sep_type            sep,
   input  logic [sfd_pkg::DW-1:0]      rest_length,
   input  logic [sfd_pkg::DW-1:0]      stiffness,
   output logic                        out_valid,
   output sfd_pkg::numer_type          numer,
   output sfd_pkg::div_side_type       side
);
   import sfd_pkg::*;

   logic [2:0]                              vld_ff;
   logic [NUM_AX-1:0][PROD_W-1:0]           p_ff, p_in;
   logic [SMAG_W-1:0]                       smag_ff, smag_in;
   div_side_type                            sa_ff, sa_in;
   logic [NUM_AX-1:0][SPLIT_W+SMAG_W-1:0]   lo_ff, lo_in;
   logic [NUM_AX-1:0][PROD_W-1:0]           hi_ff, hi_in;
   div_side_type                            sb_ff, sc_ff;
   numer_type                               numer_ff, numer_in;
   logic [FULL_W-1:0]                       full [NUM_AX];
   logic                                    short_len;

   // Stage A: |L - rest_length| and |d| * stiffness.
   always_comb begin
      short_len = {1'b0, len} < {2'b00, rest_length};
      smag_in   = short_len ? SMAG_W'({2'b00, rest_length} - {1'b0, len})
                            : SMAG_W'({1'b0, len} - {2'b00, rest_length});
      sa_in.len   = len;
      sa_in.degen = (len == '0);
      for (int i = 0; i < NUM_AX; i++) begin
         sa_in.neg[i] = sep.sgn[i] ^ short_len;
         p_in[i]      = sep.mag[i] * stiffness;
      end
   end

   // Stage B: each wide product split in two partial products.
   always_comb begin
      for (int i = 0; i < NUM_AX; i++) begin
         lo_in[i] = p_ff[i][SPLIT_W-1:0] * smag_ff;
         hi_in[i] = p_ff[i][PROD_W-1:SPLIT_W] * smag_ff;
      end
   end

   // Stage C: combine the partial products and drop the fraction bits.
   always_comb begin
      for (int i = 0; i < NUM_AX; i++) begin
         full[i]     = {hi_ff[i], SPLIT_W'(0)} + FULL_W'(lo_ff[i]);
         numer_in[i] = full[i][FULL_W-1:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff     <= p_in;
         smag_ff  <= smag_in;
         sa_ff    <= sa_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         sb_ff    <= sa_ff;
         numer_ff <= numer_in;
         sc_ff    <= sb_ff;
      end
   end

   assign out_valid = vld_ff[2];
   assign numer     = numer_ff;
   assign side      = sc_ff;

endmodule

### rtl/sfd_div.sv
// Restoring divider by the length, one quotient bit per stage, then saturation.
`timescale 1ns / 1ps

module sfd_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  sfd_pkg::numer_type     numer,
   input  sfd_pkg::div_side_type  side,
   output logic                   out_valid,
   output sfd_pkg::res_type       res
);
   import sfd_pkg::*;

   logic                             vld0_ff;
   logic [NUM_AX-1:0]                sat0_ff, sat0_in;
   logic [NUM_AX-1:0][ROOT_W-1:0]    rem0_ff, rem0_in;
   logic [NUM_AX-1:0][Q_W-1:0]       low0_ff, low0_in;
   div_side_type                     side0_ff;

   logic [NUM_AX-1:0][ROOT_W-1:0]    rem_ff  [Q_W];
   logic [NUM_AX-1:0][Q_W-1:0]       low_ff  [Q_W];
   logic [NUM_AX-1:0]                sat_ff  [Q_W];
   div_side_type                     side_ff [Q_W];
   logic [Q_W-1:0]                   vld_ff;

   logic                             vldr_ff;
   res_type                          res_ff, res_in;

   // Entry: an oversize quotient saturates; otherwise the top bits seed the remainder.
   always_comb begin
      for (int i = 0; i < NUM_AX; i++) begin
         sat0_in[i] = numer[i][NUM_W-1:Q_W] >= (NUM_W-Q_W)'(side.len);
         rem0_in[i] = numer[i][Q_W +: ROOT_W];
         low0_in[i] = numer[i][Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sat0_ff  <= sat0_in;
         rem0_ff  <= rem0_in;
         low0_ff  <= low0_in;
         side0_ff <= side;
      end
   end

   // Quotient steps: dividend bits shift out of low while quotient bits shift in.
   genvar k;
   for (k = 0; k < Q_W; k++) begin : g_step
      logic [NUM_AX-1:0][ROOT_W-1:0]  rem_src, rem_nxt;
      logic [NUM_AX-1:0][Q_W-1:0]     low_src, low_nxt;
      logic [NUM_AX-1:0]              sat_src;
      div_side_type                   side_src;
      logic                           vld_src;
      logic [ROOT_W:0]                part [NUM_AX];
      logic [NUM_AX-1:0]              ge;

      if (k == 0) begin : g_first
         assign rem_src  = rem0_ff;
         assign low_src  = low0_ff;
         assign sat_src  = sat0_ff;
         assign side_src = side0_ff;
         assign vld_src  = vld0_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign low_src  = low_ff[k-1];
         assign sat_src  = sat_ff[k-1];
         assign side_src = side_ff[k-1];
         assign vld_src  = vld_ff[k-1];
      end

      always_comb begin
         for (int i = 0; i < NUM_AX; i++) begin
            part[i]    = {rem_src[i], low_src[i][Q_W-1]};
            ge[i]      = part[i] >= {1'b0, side_src.len};
            rem_nxt[i] = ge[i] ? ROOT_W'(part[i] - {1'b0, side_src.len})
                               : part[i][ROOT_W-1:0];
            low_nxt[i] = {low_src[i][Q_W-2:0], ge[i]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_nxt;
            low_ff[k]  <= low_nxt;
            sat_ff[k]  <= sat_src;
            side_ff[k] <= side_src;
         end
      end
   end

   // Final stage: clamp to the signed range, apply the sign, clear on zero length.
   always_comb begin
      logic [Q_W-1:0] lim;
      logic [Q_W-1:0] mag;
      for (int i = 0; i < NUM_AX; i++) begin
         lim = side_ff[Q_W-1].neg[i] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
         mag = (sat_ff[Q_W-1][i] || (low_ff[Q_W-1][i] > lim)) ? lim : low_ff[Q_W-1][i];
         res_in.frc[i] = side_ff[Q_W-1].degen ? '0
                       : (side_ff[Q_W-1].neg[i] ? DW'(-mag) : mag);
      end
      res_in.degen = side_ff[Q_W-1].degen;
      res_in.span  = side_ff[Q_W-1].len[ROOT_W-1] ? '1 : side_ff[Q_W-1].len[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldr_ff <= 1'b0;
      end else if (en) begin
         vldr_ff <= vld_ff[Q_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = vldr_ff;
   assign res       = res_ff;

endmodule

### rtl/spring_force_3d.sv
// Top level of the pipelined Hookean spring force unit with its output skid stage.
`timescale 1ns / 1ps
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_tvalid/tready  | tdata: first_x,y,z, second_x,y,z
//   rsp     | out       | rsp_tvalid/tready  | tdata: force_x,y,z, span_length; tuser
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// One item enters per cycle while the skid register is empty. The path has 75
// register stages: 4 front stages, 33 square root stages, 3 scaling stages,
// 34 divider stages (entry, 32 quotient steps, clamp) and the output register.
// Reset clears all valid bits and both configuration registers to zero.
// The pipeline advances as one while the skid register is empty; a stalled
// result parks the next one in the skid register and then holds the pipeline.
// The configuration port takes a write in every cycle.

module spring_force_3d (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // first_x, first_y, first_z, second_x, second_y, second_z
   input  logic [6*sfd_pkg::DW-1:0]       req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // force_x, force_y, force_z, span_length
   output logic [4*sfd_pkg::DW-1:0]       rsp_tdata,
   // degenerate
   output logic                           rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfd_pkg::DW-1:0]         csr_data
);
   import sfd_pkg::*;

   logic [DW-1:0]      rest_length_ff, stiffness_ff;
   logic               pipe_en;
   logic               fr_valid, sq_valid, sc_valid, dv_valid;
   sq_type             sum_sq;
   sep_type            fr_sep, sq_sep;
   logic [ROOT_W-1:0]  len;
   numer_type          numer;
   div_side_type       side;
   res_type            dv_res;
   res_type            out_ff, skid_ff;
   logic               out_valid_ff, skid_valid_ff;
   logic               take;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_length_ff <= '0;
         stiffness_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REST_LENGTH: rest_length_ff <= csr_data;
            CSR_STIFFNESS:   stiffness_ff   <= csr_data;
            default:         ;
         endcase
      end
   end

   // The pipeline moves whenever the skid register is free.
   assign pipe_en    = !skid_valid_ff;
   assign req_tready = pipe_en;

   sfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .in_valid   (req_tvalid),
      .first_pos  (req_tdata[3*DW-1:0]),
      .second_pos (req_tdata[6*DW-1:3*DW]),
      .out_valid  (fr_valid),
      .sum_sq     (sum_sq),
      .sep        (fr_sep)
   );

   sfd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (fr_valid),
      .radicand  (sum_sq),
      .sep_in    (fr_sep),
      .out_valid (sq_valid),
      .root      (len),
      .sep_out   (sq_sep)
   );

   sfd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_valid    (sq_valid),
      .len         (len),
      .sep         (sq_sep),
      .rest_length (rest_length_ff),
      .stiffness   (stiffness_ff),
      .out_valid   (sc_valid),
      .numer       (numer),
      .side        (side)
   );

   sfd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (sc_valid),
      .numer     (numer),
      .side      (side),
      .out_valid (dv_valid),
      .res       (dv_res)
   );

   // Output register with a skid register behind it.
   assign take = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (dv_valid) begin
         if (out_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (dv_valid) begin
         if (out_valid_ff && !take) begin
            skid_ff <= dv_res;
         end else begin
            out_ff <= dv_res;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.span, out_ff.frc};
   assign rsp_tuser  = out_ff.degen;

   // The skid register only ever holds an item behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register is empty");

   // The skid register fills only after a stalled result.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid register filled without a stalled result");

   // A zero separation gives zero force and zero length.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("degenerate result carries nonzero data");

   // Any other result has a nonzero length.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (out_ff.span != '0))
      else $error("nonzero separation reported with zero length");

endmodule
